// ===== design/mpp_pkg.sv =====
// Shared types and constants for the motor position PID/PWM controller.
`default_nettype none

package mpp_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned ERR_W      = 24;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned LIMIT_W    = 31;
  localparam int unsigned DUTY_W     = 8;
  localparam int unsigned DRIVE_W    = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET   = 3'd0,
    CFG_KP       = 3'd1,
    CFG_KI       = 3'd2,
    CFG_KD       = 3'd3,
    CFG_DEADBAND = 3'd4,
    CFG_ILIMIT   = 3'd5,
    CFG_MIN_DUTY = 3'd6,
    CFG_HOLD_OFF = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DRV_BRAKE   = 2'd0,
    DRV_REVERSE = 2'd1,
    DRV_PID     = 2'd2
  } drv_sel_e;

endpackage

`default_nettype wire

// ===== design/mpp_if.sv =====
// Handshake interfaces for encoder items and duty items.
`default_nettype none

interface mpp_enc_if;
  import mpp_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] encoder_count;

  modport source (output valid, output encoder_count, input ready);
  modport sink (input valid, input encoder_count, output ready);
endinterface

interface mpp_duty_if;
  import mpp_pkg::*;

  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] forward_duty;
  logic [DUTY_W-1:0] reverse_duty;
  logic              at_target;

  modport source (output valid, output forward_duty, output reverse_duty, output at_target,
                  input ready);
  modport sink (input valid, input forward_duty, input reverse_duty, input at_target,
                output ready);
endinterface

`default_nettype wire

// ===== design/motor_position_pid_pwm.sv =====
// Motor position PID controller producing forward/reverse PWM duties.
//
//   channel   dir  payload                                   protocol
//   enc_i     in   encoder_count[31:0] signed                valid/ready
//   duty_o    out  forward_duty[7:0] reverse_duty[7:0] at_target  valid/ready
//   cfg       in   cfg_we_i cfg_idx_i[2:0] cfg_data_i[31:0]   write only
//
// Five register stages: input, error/accumulator, products, drive, output.
// One item per cycle while the output accepts; stages advance independently,
// so bubbles collapse. Input stays ready while any stage is empty and drops
// only when all five stages hold items behind a stalled output. Accumulator
// and previous error update in the error stage, so each item sees the state
// left by the item before it unless a configuration write blocked the update.
// Reset clears control, controller state and configuration to defaults.
`default_nettype none

module motor_position_pid_pwm #(
  parameter int unsigned PWM_FULL_SCALE = 255
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mpp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mpp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mpp_enc_if.sink                             enc_i,
  mpp_duty_if.source                          duty_o
);
  import mpp_pkg::*;

  localparam logic signed [DRIVE_W-1:0] FullS = DRIVE_W'(PWM_FULL_SCALE);

  // configuration
  logic signed [COUNT_W-1:0] target_q;
  logic [GAIN_W-1:0]         kp_q, ki_q, kd_q, deadband_q;
  logic [LIMIT_W-1:0]        ilimit_q;
  logic [DUTY_W-1:0]         min_duty_q;
  logic                      hold_off_q;

  // controller state
  logic signed [31:0]        error_sum_q;
  logic signed [ERR_W-1:0]   last_error_q;
  logic                      reached_q;

  // pipeline
  logic                      v1_q, v2_q, v3_q, v4_q, v5_q;
  logic                      adv1, adv2, adv3, adv4, adv5;
  logic signed [COUNT_W-1:0] count1_q;

  drv_sel_e                  sel2_d, sel2_q, sel3_q;
  logic                      at2_d, at2_q, at3_q, at4_q, at5_q;
  logic signed [ERR_W-1:0]   err2_d, err2_q;
  logic signed [31:0]        sum2_d, sum2_q;
  logic signed [ERR_W:0]     deriv2_d, deriv2_q;

  logic signed [40:0]        pp_d, pp_q;
  logic signed [48:0]        ip_d, ip_q;
  logic signed [41:0]        dp_d, dp_q;

  logic signed [DRIVE_W-1:0] drive4_d, drive4_q;
  logic [DUTY_W-1:0]         fwd5_d, fwd5_q, rev5_d, rev5_q;

  // stage 2 combinational
  logic signed [COUNT_W:0]   diff;
  logic [ERR_W-1:0]          err_mag;
  logic                      in_dead;
  logic signed [COUNT_W:0]   sum33, lim33;
  logic                      fire2;

  // stage 4 combinational
  logic signed [50:0]        acc;
  logic signed [42:0]        quo;
  logic signed [42:0]        full43;

  // stage 5 combinational
  logic [DRIVE_W-1:0]        mag5;

  assign adv5 = !v5_q || duty_o.ready;
  assign adv4 = !v4_q || adv5;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign fire2 = adv2 && v1_q;

  assign enc_i.ready         = adv1;
  assign duty_o.valid        = v5_q;
  assign duty_o.forward_duty = fwd5_q;
  assign duty_o.reverse_duty = rev5_q;
  assign duty_o.at_target    = at5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= enc_i.valid;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
      if (adv5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) count1_q <= enc_i.encoder_count;
    if (adv2) begin
      sel2_q   <= sel2_d;
      at2_q    <= at2_d;
      err2_q   <= err2_d;
      sum2_q   <= sum2_d;
      deriv2_q <= deriv2_d;
    end
    if (adv3) begin
      sel3_q <= sel2_q;
      at3_q  <= at2_q;
      pp_q   <= pp_d;
      ip_q   <= ip_d;
      dp_q   <= dp_d;
    end
    if (adv4) begin
      at4_q    <= at3_q;
      drive4_q <= drive4_d;
    end
    if (adv5) begin
      fwd5_q <= fwd5_d;
      rev5_q <= rev5_d;
      at5_q  <= at4_q;
    end
  end

  // error, deadband, accumulator, derivative, drive select and at-target flag
  always_comb begin
    diff = {target_q[COUNT_W-1], target_q} - {count1_q[COUNT_W-1], count1_q};
    if (diff[COUNT_W:ERR_W-1] == {(COUNT_W-ERR_W+2){diff[ERR_W-1]}}) begin
      err2_d = diff[ERR_W-1:0];
    end else if (diff[COUNT_W]) begin
      err2_d = {1'b1, {(ERR_W-1){1'b0}}};
    end else begin
      err2_d = {1'b0, {(ERR_W-1){1'b1}}};
    end
    err_mag = err2_d[ERR_W-1] ? ERR_W'(-err2_d) : err2_d;
    in_dead = err_mag <= {{(ERR_W-GAIN_W){1'b0}}, deadband_q};

    sum33 = {error_sum_q[31], error_sum_q} + {{(COUNT_W-ERR_W+1){err2_d[ERR_W-1]}}, err2_d};
    lim33 = {2'b00, ilimit_q};
    if (sum33 > lim33) begin
      sum2_d = lim33[31:0];
    end else if (sum33 < -lim33) begin
      sum2_d = 32'(-lim33);
    end else begin
      sum2_d = sum33[31:0];
    end
    deriv2_d = {err2_d[ERR_W-1], err2_d} - {last_error_q[ERR_W-1], last_error_q};

    if (hold_off_q || in_dead) begin
      sel2_d = DRV_BRAKE;
    end else if (!err2_d[ERR_W-1] && err2_d != '0) begin
      sel2_d = DRV_PID;
    end else begin
      sel2_d = DRV_REVERSE;
    end
    at2_d = (!hold_off_q && in_dead) ? 1'b1 : reached_q;
  end

  // configuration registers and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= '0;
      kp_q         <= GAIN_W'(256);
      ki_q         <= '0;
      kd_q         <= '0;
      deadband_q   <= '0;
      ilimit_q     <= LIMIT_W'(65535);
      min_duty_q   <= '0;
      hold_off_q   <= 1'b0;
      error_sum_q  <= '0;
      last_error_q <= '0;
      reached_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_TARGET: begin
          target_q     <= cfg_data_i;
          error_sum_q  <= '0;
          last_error_q <= '0;
          reached_q    <= 1'b0;
        end
        CFG_KP:       kp_q       <= cfg_data_i[GAIN_W-1:0];
        CFG_KI:       ki_q       <= cfg_data_i[GAIN_W-1:0];
        CFG_KD:       kd_q       <= cfg_data_i[GAIN_W-1:0];
        CFG_DEADBAND: deadband_q <= cfg_data_i[GAIN_W-1:0];
        CFG_ILIMIT:   ilimit_q   <= cfg_data_i[LIMIT_W-1:0];
        CFG_MIN_DUTY: min_duty_q <= cfg_data_i[DUTY_W-1:0];
        CFG_HOLD_OFF: hold_off_q <= cfg_data_i[0];
      endcase
    end else if (fire2 && !hold_off_q) begin
      if (in_dead) begin
        error_sum_q  <= '0;
        last_error_q <= '0;
        reached_q    <= 1'b1;
      end else begin
        error_sum_q  <= sum2_d;
        last_error_q <= err2_d;
      end
    end
  end

  // gain products
  always_comb begin
    pp_d = $signed({1'b0, kp_q}) * err2_q;
    ip_d = $signed({1'b0, ki_q}) * sum2_q;
    dp_d = $signed({1'b0, kd_q}) * deriv2_q;
  end

  // Q8.8 sum, truncate toward zero, clamp to full scale; else full reverse or 0
  always_comb begin
    acc = 51'(pp_q) + 51'(ip_q) + 51'(dp_q);
    quo = acc[50:8];
    if (acc[50] && acc[7:0] != '0) begin
      quo = quo + 43'sd1;
    end
    full43 = 43'(FullS);
    unique case (sel3_q)
      DRV_PID: begin
        if (quo > full43) begin
          drive4_d = FullS;
        end else if (quo < -full43) begin
          drive4_d = -FullS;
        end else begin
          drive4_d = quo[DRIVE_W-1:0];
        end
      end
      DRV_REVERSE: drive4_d = -FullS;
      default:     drive4_d = '0;
    endcase
  end

  // duty split
  always_comb begin
    mag5 = drive4_q[DRIVE_W-1] ? DRIVE_W'(-drive4_q) : drive4_q;
    if (mag5 < {{(DRIVE_W-DUTY_W){1'b0}}, min_duty_q}) begin
      mag5 = {{(DRIVE_W-DUTY_W){1'b0}}, min_duty_q};
    end
    if (mag5 > DRIVE_W'(255)) begin
      mag5 = DRIVE_W'(255);
    end
    if (drive4_q == '0) begin
      fwd5_d = DUTY_W'(1);
      rev5_d = DUTY_W'(1);
    end else if (drive4_q[DRIVE_W-1]) begin
      fwd5_d = '0;
      rev5_d = mag5[DUTY_W-1:0];
    end else begin
      fwd5_d = mag5[DUTY_W-1:0];
      rev5_d = '0;
    end
  end

endmodule

`default_nettype wire

// ===== design/mpp_checker.sv =====
// Port-level checks for the motor position controller, bound to the top level.
`default_nettype none

module mpp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] forward_duty_i,
  input wire logic [7:0] reverse_duty_i,
  input wire logic       at_target_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i
      && $stable(forward_duty_i) && $stable(reverse_duty_i) && $stable(at_target_i))
    else $error("stalled item changed");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty output");

  a_brake_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && forward_duty_i != 8'd0 && reverse_duty_i != 8'd0
      |-> forward_duty_i == 8'd1 && reverse_duty_i == 8'd1)
    else $error("both directions driven");

  a_never_coast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> forward_duty_i != 8'd0 || reverse_duty_i != 8'd0)
    else $error("zero duty on both channels");

endmodule

bind motor_position_pid_pwm mpp_checker u_mpp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (enc_i.valid),
  .in_ready_i     (enc_i.ready),
  .out_valid_i    (duty_o.valid),
  .out_ready_i    (duty_o.ready),
  .forward_duty_i (duty_o.forward_duty),
  .reverse_duty_i (duty_o.reverse_duty),
  .at_target_i    (duty_o.at_target)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for motor_position_pid_pwm: PID duty prediction and result checks.
`timescale 1ns / 1ps

import mpp_pkg::*;

typedef struct packed {
  logic [DUTY_W-1:0] fwd;
  logic [DUTY_W-1:0] rev;
  logic              at;
} duty_t;

class duty_scoreboard;
  localparam longint FULL = 255;
  localparam longint ERR_MAX = 8388607;
  localparam longint ERR_MIN = -8388608;

  logic signed [31:0] target;
  logic [15:0]        kp;
  logic [15:0]        ki;
  logic [15:0]        kd;
  logic [15:0]        deadband;
  logic [30:0]        ilimit;
  logic [7:0]         min_duty;
  logic               hold;

  logic signed [31:0] err_sum;
  logic signed [23:0] last_err;
  logic               reached;

  duty_t expected_duties[$];
  int    mismatches;
  int    checked;

  function new();
    target   = '0;
    kp       = 16'd256;
    ki       = '0;
    kd       = '0;
    deadband = '0;
    ilimit   = 31'd65535;
    min_duty = '0;
    hold     = 1'b0;
    err_sum  = '0;
    last_err = '0;
    reached  = 1'b0;
    mismatches = 0;
    checked  = 0;
  endfunction

  function void write_reg(cfg_reg_e idx, logic [31:0] d);
    case (idx)
      CFG_TARGET: begin
        target   = d;
        err_sum  = '0;
        last_err = '0;
        reached  = 1'b0;
      end
      CFG_KP:       kp = d[15:0];
      CFG_KI:       ki = d[15:0];
      CFG_KD:       kd = d[15:0];
      CFG_DEADBAND: deadband = d[15:0];
      CFG_ILIMIT:   ilimit = d[30:0];
      CFG_MIN_DUTY: min_duty = d[7:0];
      CFG_HOLD_OFF: hold = d[0];
      default: ;
    endcase
  endfunction

  function duty_t compute_duty(logic [31:0] count);
    duty_t  d;
    longint e;
    longint mag;
    longint s;
    longint lim;
    longint dv;
    longint acc;
    longint drv;
    d.fwd = 8'd1;
    d.rev = 8'd1;
    d.at  = reached;
    if (hold) begin
      return d;
    end
    e = longint'(target) - longint'($signed(count));
    if (e > ERR_MAX) e = ERR_MAX;
    if (e < ERR_MIN) e = ERR_MIN;
    mag = (e < 0) ? -e : e;
    if (mag <= longint'(deadband)) begin
      err_sum  = '0;
      last_err = '0;
      reached  = 1'b1;
      d.at     = 1'b1;
      return d;
    end
    lim = longint'(ilimit);
    s = longint'(err_sum) + e;
    if (s > lim) s = lim;
    if (s < -lim) s = -lim;
    err_sum = s[31:0];
    dv = e - longint'(last_err);
    acc = longint'(kp) * e + longint'(ki) * s + longint'(kd) * dv;
    last_err = e[23:0];
    drv = (e > 0) ? acc / 256 : -FULL;
    if (drv > FULL) drv = FULL;
    if (drv < -FULL) drv = -FULL;
    if (drv != 0) begin
      mag = (drv > 0) ? drv : -drv;
      if (mag < longint'(min_duty)) mag = longint'(min_duty);
      if (mag > 255) mag = 255;
      d.fwd = (drv > 0) ? mag[7:0] : 8'd0;
      d.rev = (drv > 0) ? 8'd0 : mag[7:0];
    end
    d.at = reached;
    return d;
  endfunction

  function void note_count(logic [31:0] count);
    expected_duties.push_back(compute_duty(count));
  endfunction

  task report(string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  task check_duty(logic [7:0] fwd, logic [7:0] rev, logic at);
    duty_t want;
    if (expected_duties.size() == 0) begin
      report($sformatf("unexpected duty item fwd=%0d rev=%0d at=%0b", fwd, rev, at));
      return;
    end
    want = expected_duties.pop_front();
    checked++;
    if (fwd !== want.fwd) report($sformatf("item %0d forward_duty %0d, want %0d",
                                           checked, fwd, want.fwd));
    if (rev !== want.rev) report($sformatf("item %0d reverse_duty %0d, want %0d",
                                           checked, rev, want.rev));
    if (at !== want.at) report($sformatf("item %0d at_target %0b, want %0b",
                                         checked, at, want.at));
  endtask

  function int pending();
    return expected_duties.size();
  endfunction
endclass

module tb_top;
  localparam int LATENCY     = 5;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RAND_ITEMS  = 1100;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  mpp_enc_if  enc_ch ();
  mpp_duty_if duty_ch ();

  motor_position_pid_pwm u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .enc_i      (enc_ch),
    .duty_o     (duty_ch)
  );

  duty_scoreboard sb = new();

  int cycles;
  int send_mode;
  int recv_mode;
  int items_sent;
  int phases;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic int draw_gap(int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 18);
      default: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
    endcase
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_reg_e'(cfg_idx_i), cfg_data_i);
      if (enc_ch.valid && enc_ch.ready) sb.note_count(enc_ch.encoder_count);
      if (duty_ch.valid && duty_ch.ready)
        sb.check_duty(duty_ch.forward_duty, duty_ch.reverse_duty, duty_ch.at_target);
    end
  end

  initial begin
    int stall;
    duty_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = draw_gap(recv_mode);
      if (stall > 0) begin
        duty_ch.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      duty_ch.ready = 1'b1;
      do @(posedge clk_i); while (!duty_ch.valid);
      @(negedge clk_i);
    end
  end

  task send_count(input logic [31:0] count);
    int gap;
    gap = draw_gap(send_mode);
    if (gap > 0) begin
      enc_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    enc_ch.valid = 1'b1;
    enc_ch.encoder_count = count;
    do @(posedge clk_i); while (!enc_ch.ready);
    @(negedge clk_i);
    items_sent++;
  endtask

  task drain();
    enc_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (LATENCY + 3) @(negedge clk_i);
  endtask

  task set_reg(input cfg_reg_e idx, input logic [31:0] d);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = d;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 1023));
      3:       return 16'($urandom_range(64, 512));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_target();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'd0;
      3:       return 32'($signed($urandom_range(0, 200000)) - 100000);
      default: return $urandom;
    endcase
  endfunction

  task randomize_settings();
    if ($urandom_range(0, 2) != 0) set_reg(CFG_TARGET, pick_target());
    if ($urandom_range(0, 3) != 0) set_reg(CFG_KP, pick_gain());
    if ($urandom_range(0, 3) != 0) set_reg(CFG_KI, pick_gain());
    if ($urandom_range(0, 3) != 0) set_reg(CFG_KD, pick_gain());
    case ($urandom_range(0, 4))
      0: set_reg(CFG_DEADBAND, 32'd0);
      1: set_reg(CFG_DEADBAND, 32'd65535);
      2: set_reg(CFG_DEADBAND, $urandom_range(0, 50));
      3: set_reg(CFG_DEADBAND, $urandom_range(0, 65535));
      default: ;
    endcase
    case ($urandom_range(0, 4))
      0: set_reg(CFG_ILIMIT, 32'd0);
      1: set_reg(CFG_ILIMIT, 32'h7FFF_FFFF);
      2: set_reg(CFG_ILIMIT, $urandom_range(0, 5000));
      3: set_reg(CFG_ILIMIT, $urandom);
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0: set_reg(CFG_MIN_DUTY, 32'd0);
      1: set_reg(CFG_MIN_DUTY, 32'd255);
      2: set_reg(CFG_MIN_DUTY, $urandom);
      default: ;
    endcase
    set_reg(CFG_HOLD_OFF, ($urandom_range(0, 7) == 0) ? 32'd1 : 32'd0);
  endtask

  function automatic longint start_error();
    longint e;
    case ($urandom_range(0, 3))
      0:       e = $urandom_range(0, 255);
      1:       e = $urandom_range(0, 65535);
      2:       e = $urandom_range(0, 16777215);
      default: e = $urandom;
    endcase
    return ($urandom_range(0, 1) == 0) ? e : -e;
  endfunction

  task run_phase(input int n);
    longint cur_err;
    longint db;
    int     k;
    cur_err = start_error();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 39) == 0) drain();
      k = $urandom_range(0, 9);
      db = longint'(sb.deadband);
      if (k < 6) begin
        cur_err = cur_err - (cur_err * longint'($urandom_range(0, 4))) / 8
                  + longint'($urandom_range(0, 20)) - 10;
        send_count(32'(longint'(sb.target) - cur_err));
      end else if (k < 8) begin
        send_count($urandom);
      end else if (k == 8) begin
        cur_err = start_error();
        send_count(32'(longint'(sb.target) - cur_err));
      end else begin
        cur_err = db + longint'($urandom_range(0, 1));
        if ($urandom_range(0, 1) == 0) cur_err = -cur_err;
        send_count(32'(longint'(sb.target) - cur_err));
      end
    end
  endtask

  initial begin
    items_sent  = 0;
    phases      = 0;
    send_mode   = 0;
    recv_mode   = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_TARGET;
    cfg_data_i  = '0;
    enc_ch.valid = 1'b0;
    enc_ch.encoder_count = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // defaults after reset: proportional gain only, target zero
    send_mode = 2;
    recv_mode = 2;
    send_count(32'd0);
    send_count(-32'sd100);
    send_count(32'd100);
    send_count(32'h8000_0000);
    send_count(32'h7FFF_FFFF);
    send_count(-32'sd1);

    drain();
    set_reg(CFG_TARGET, 32'h7FFF_FFFF);
    set_reg(CFG_MIN_DUTY, 32'd40);
    set_reg(CFG_KI, 32'hFFFF);
    set_reg(CFG_KD, 32'hFFFF);
    set_reg(CFG_ILIMIT, 32'h7FFF_FFFF);
    send_count(32'h8000_0000);
    send_count(32'h7FFF_FFFC);

    // target at the minimum: counts wrap high, so every error is negative and drives full reverse
    drain();
    set_reg(CFG_TARGET, 32'h8000_0000);
    set_reg(CFG_KP, 32'd0);
    set_reg(CFG_KI, 32'd0);
    set_reg(CFG_ILIMIT, 32'd0);
    send_count(32'h7FFF_FFFF);
    send_count(32'h8000_0000 - 32'd5000);
    send_count(32'h8000_0000 - 32'd10);
    send_count(32'h8000_0000 - 32'd1);

    // zero gains: a negative error still yields full reverse
    drain();
    set_reg(CFG_KD, 32'd0);
    set_reg(CFG_MIN_DUTY, 32'd255);
    send_count(32'h8000_0000 - 32'd7);

    drain();
    set_reg(CFG_KP, 32'd1);
    set_reg(CFG_MIN_DUTY, 32'd200);
    send_count(32'h8000_0000 - 32'd300);

    // deadband at its widest; one error lies just beyond its edge
    drain();
    set_reg(CFG_DEADBAND, 32'd65535);
    send_count(32'h8000_0000 - 32'd65535);
    send_count(32'h8000_0000 + 32'd65536);
    send_count(32'h8000_0000 - 32'd65536);

    drain();
    set_reg(CFG_HOLD_OFF, 32'd1);
    send_count(32'h8000_0000);
    send_count($urandom);

    // integral clamp on a steady error
    drain();
    set_reg(CFG_HOLD_OFF, 32'd0);
    set_reg(CFG_DEADBAND, 32'd0);
    set_reg(CFG_KP, 32'd256);
    set_reg(CFG_KI, 32'd256);
    set_reg(CFG_ILIMIT, 32'd100);
    set_reg(CFG_MIN_DUTY, 32'd0);
    set_reg(CFG_TARGET, 32'd0);
    send_count(-32'sd50);
    send_count(-32'sd50);
    send_count(-32'sd50);
    send_count(32'd0);

    while (items_sent < RAND_ITEMS + 25) begin
      drain();
      phases++;
      send_mode = (phases % 7 == 3) ? 0 : $urandom_range(0, 2);
      recv_mode = (phases % 7 == 3) ? 0 : $urandom_range(0, 2);
      randomize_settings();
      run_phase($urandom_range(20, 80));
    end

    drain();
    repeat (LATENCY * 2) @(negedge clk_i);
    $display("ran %0d encoder items across %0d random setting phases plus directed cases",
             items_sent, phases);
    $display("checked %0d duty items, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
design/mpp_pkg.sv
design/mpp_if.sv
design/motor_position_pid_pwm.sv
design/mpp_checker.sv
tb/tb_top.sv
